FILE: rtl/mcrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrg_pkg
// Shared types and constants of the midpoint circle row generator.
// ----------------------------------------------------------------------------
package mcrg_pkg;

  localparam int RADIUS_W_DEF = 10;   // default radius width inside the block
  localparam int RADIUS_IN_W  = 10;   // width of the radius input field
  localparam int RADIUS_EXT_W = 16;   // radius field widened before trimming
  localparam int CENTRE_W     = 16;
  localparam int COORD_W      = 17;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Row codes within one iteration, in output order.
  localparam logic [1:0] ROW_TOP_Y    = 2'd0;
  localparam logic [1:0] ROW_BOTTOM_Y = 2'd1;
  localparam logic [1:0] ROW_TOP_X    = 2'd2;
  localparam logic [1:0] ROW_BOTTOM_X = 2'd3;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic                       idle;   // step taken with no circle active
    logic                       done;   // this iteration ends the circle
    logic                       fill;
    logic signed [CENTRE_W-1:0] cx;
    logic signed [CENTRE_W-1:0] cy;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/mcrg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrg_front
// Holds the circle state, takes start and step words and runs one midpoint
// iteration per step word while active, posting a job for the row expander.
// ----------------------------------------------------------------------------
module mcrg_front import mcrg_pkg::*; #(
  parameter int RADIUS_WIDTH = RADIUS_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  logic                       in_op,
  input  logic signed [CENTRE_W-1:0] in_center_x,
  input  logic signed [CENTRE_W-1:0] in_center_y,
  input  logic [RADIUS_IN_W-1:0]     in_radius,
  input  logic                       in_fill,
  output logic                       job_push,
  output job_t                       job
);

  localparam int XW = RADIUS_WIDTH + 1;
  localparam int SW = RADIUS_WIDTH + 2;
  localparam int EW = RADIUS_WIDTH + 3;

  logic signed [CENTRE_W-1:0] centre_col_r, centre_row_r;
  logic signed [XW-1:0]       x_r, x_nxt;
  logic [RADIUS_WIDTH-1:0]    y_r, y_nxt;
  logic [SW-1:0]              xs_r, xs_nxt, ys_r, ys_nxt;
  logic signed [EW-1:0]       err_r, err_nxt, err_mid;
  logic [XW-1:0]              tr_r;
  logic                       fill_r, active_r;

  logic [RADIUS_EXT_W-1:0]    rad_ext;
  logic [RADIUS_WIDTH-1:0]    rad;
  logic                       done;

  assign rad_ext = {{(RADIUS_EXT_W-RADIUS_IN_W){1'b0}}, in_radius};
  assign rad     = rad_ext[RADIUS_WIDTH-1:0];

  // One iteration: the y move, then the x move on the updated error.
  always_comb begin
    y_nxt   = y_r;
    ys_nxt  = ys_r;
    err_mid = err_r;
    if (err_r[EW-1] || err_r == '0) begin
      y_nxt   = y_r + RADIUS_WIDTH'(1);
      err_mid = err_r + $signed({1'b0, ys_r});
      ys_nxt  = ys_r + SW'(2);
    end
    x_nxt   = x_r;
    xs_nxt  = xs_r;
    err_nxt = err_mid;
    if (!err_mid[EW-1] && err_mid != '0) begin
      x_nxt   = x_r - XW'(1);
      xs_nxt  = xs_r + SW'(2);
      err_nxt = err_mid + $signed({1'b0, xs_nxt}) - $signed({2'b0, tr_r});
    end
  end

  assign done = x_nxt < $signed({1'b0, y_nxt});

  assign job_push  = in_take && (in_op == OP_STEP);
  assign job.idle  = !active_r;
  assign job.done  = done;
  assign job.fill  = fill_r;
  assign job.cx    = centre_col_r;
  assign job.cy    = centre_row_r;
  assign job.x     = COORD_W'(x_r);
  assign job.y     = COORD_W'(y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_col_r <= '0;
      centre_row_r <= '0;
      x_r          <= '0;
      y_r          <= '0;
      xs_r         <= SW'(1);
      ys_r         <= SW'(1);
      err_r        <= '0;
      tr_r         <= '0;
      fill_r       <= 1'b0;
      active_r     <= 1'b0;
    end else if (in_take) begin
      if (in_op == OP_START) begin
        centre_col_r <= in_center_x;
        centre_row_r <= in_center_y;
        fill_r       <= in_fill;
        tr_r         <= {rad, 1'b0};
        x_r          <= $signed({1'b0, rad} - XW'(1));
        y_r          <= '0;
        xs_r         <= SW'(1);
        ys_r         <= SW'(1);
        err_r        <= $signed(EW'(1) - {1'b0, rad, 1'b0});
        active_r     <= rad != '0;
      end else if (active_r) begin
        x_r      <= x_nxt;
        y_r      <= y_nxt;
        xs_r     <= xs_nxt;
        ys_r     <= ys_nxt;
        err_r    <= err_nxt;
        active_r <= !done;
      end
    end
  end

endmodule

FILE: rtl/mcrg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrg_queue
// Short job queue between the iteration front and the row expander.
// ----------------------------------------------------------------------------
module mcrg_queue import mcrg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  job_t    wr_job,
  input  logic    rd_en,
  output job_t    rd_job,
  output q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign stat.full  = count_r == CW'(DEPTH);
  assign stat.empty = count_r == '0;
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_job     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/mcrg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrg_back
// Expands each job into its four symmetric rows, or one idle word, and
// holds the oldest row in the output register.
// ----------------------------------------------------------------------------
module mcrg_back import mcrg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  job_t                      q_job,
  input  q_stat_t                   q_stat,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic signed [COORD_W-1:0] out_row_y,
  output logic signed [COORD_W-1:0] out_left_x,
  output logic signed [COORD_W-1:0] out_right_x,
  output logic                      out_span_mode,
  output logic                      out_status,
  output logic                      out_last_row,
  output logic                      out_circle_done
);

  job_t                      cur_r;
  logic                      cur_valid_r;
  logic [1:0]                idx_r;
  logic                      out_valid_r;

  logic signed [COORD_W-1:0] cx, cy, row_off, col_off;
  logic signed [COORD_W-1:0] row_v, left_v, right_v;
  logic                      row_last, load, take_job;

  assign cx      = COORD_W'(cur_r.cx);
  assign cy      = COORD_W'(cur_r.cy);
  // The first two rows sit at y from the centre, the last two at x.
  assign row_off = idx_r[1] ? cur_r.x : cur_r.y;
  assign col_off = idx_r[1] ? cur_r.y : cur_r.x;
  assign row_v   = idx_r[0] ? cy + row_off : cy - row_off;
  assign left_v  = cx - col_off;
  assign right_v = cx + col_off;

  assign row_last = cur_r.idle || (idx_r == ROW_BOTTOM_X);
  assign load     = cur_valid_r && (!out_valid_r || pop);
  assign take_job = !cur_valid_r || (load && row_last);
  assign q_pop    = take_job && !q_stat.empty;
  assign empty    = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= ROW_TOP_Y;
      out_valid_r <= 1'b0;
    end else begin
      if (take_job) begin
        cur_valid_r <= !q_stat.empty;
        idx_r       <= ROW_TOP_Y;
      end else if (load) begin
        idx_r <= idx_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end
    if (load) begin
      if (cur_r.idle) begin
        out_row_y       <= '0;
        out_left_x      <= '0;
        out_right_x     <= '0;
        out_span_mode   <= 1'b0;
        out_status      <= 1'b1;
        out_last_row    <= 1'b1;
        out_circle_done <= 1'b0;
      end else begin
        out_row_y       <= row_v;
        out_left_x      <= left_v;
        out_right_x     <= right_v;
        out_span_mode   <= cur_r.fill;
        out_status      <= 1'b0;
        out_last_row    <= row_last;
        out_circle_done <= row_last && cur_r.done;
      end
    end
  end

endmodule

FILE: rtl/midpoint_circle_row_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_row_generator_top
// Midpoint circle rasteriser producing four symmetric rows per iteration.
//
//   channel  handshake     payload
//   input    push / full   in_op, in_center_x, in_center_y, in_radius_in,
//                          in_fill_req
//   result   empty / pop   out_row_y, out_left_x, out_right_x, out_span_mode,
//                          out_status, out_last_row, out_circle_done
//
// The front takes a word per cycle while its two-job queue has room; the
// iteration runs in that cycle. A step yields four rows, issued one per cycle
// from the row expander while pop is held, so steady steps are limited by its
// single output register. A start gives no row; an idle step gives one word.
// Reset is synchronous and leaves no circle active. Stalling pop backs up the
// queue, which raises full.
// ----------------------------------------------------------------------------
module midpoint_circle_row_generator_top import mcrg_pkg::*; #(
  parameter int RADIUS_WIDTH = RADIUS_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_op,
  input  logic signed [CENTRE_W-1:0] in_center_x,
  input  logic signed [CENTRE_W-1:0] in_center_y,
  input  logic [RADIUS_IN_W-1:0]     in_radius_in,
  input  logic                       in_fill_req,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [COORD_W-1:0]  out_row_y,
  output logic signed [COORD_W-1:0]  out_left_x,
  output logic signed [COORD_W-1:0]  out_right_x,
  output logic                       out_span_mode,
  output logic                       out_status,
  output logic                       out_last_row,
  output logic                       out_circle_done
);

  logic    in_take, job_push, q_pop;
  job_t    job_in, job_out;
  q_stat_t q_stat;

  assign full    = q_stat.full;
  assign in_take = push && !full;

  mcrg_front #(
    .RADIUS_WIDTH(RADIUS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_op      (in_op),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius  (in_radius_in),
    .in_fill    (in_fill_req),
    .job_push   (job_push),
    .job        (job_in)
  );

  mcrg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (job_push),
    .wr_job(job_in),
    .rd_en (q_pop),
    .rd_job(job_out),
    .stat  (q_stat)
  );

  mcrg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_job          (job_out),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_row_y      (out_row_y),
    .out_left_x     (out_left_x),
    .out_right_x    (out_right_x),
    .out_span_mode  (out_span_mode),
    .out_status     (out_status),
    .out_last_row   (out_last_row),
    .out_circle_done(out_circle_done)
  );

  // A finished circle is only ever flagged on the closing row of a step.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_circle_done |-> out_last_row && !out_status)
    else $error("circle_done flagged away from the last row");

  // An idle answer carries no coordinates.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status |-> out_row_y == '0 && out_left_x == '0 &&
                             out_right_x == '0 && out_last_row)
    else $error("idle word carries row data");

  // The queue cannot be full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue reports full and empty");

  // Reset leaves nothing on the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result waiting straight after reset");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the midpoint circle row generator.
//
// A short table of directed words covers the idle reply, zero and full
// radius, extreme centres, both drawing modes and a restart during a circle.
// Random circles follow, mostly well-formed runs of steps after a start,
// with some stray words mixed in. Every accepted word is fed to a local
// model of the rasteriser, and each popped row is compared with the oldest
// predicted row. Both sides idle at random in the first two of three phases.
// The receiver also holds off for a long stretch so that full is raised.
// ----------------------------------------------------------------------------
module tb_top import mcrg_pkg::*; ();

  localparam int RADIUS_WIDTH  = RADIUS_W_DEF;
  localparam int RANDOM_WORDS  = 260;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic signed [COORD_W-1:0] row_y;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] right_x;
    logic                      span_mode;
    logic                      status;
    logic                      last_row;
    logic                      circle_done;
  } row_word_t;

  typedef struct packed {
    logic                       op;
    logic signed [CENTRE_W-1:0] cx;
    logic signed [CENTRE_W-1:0] cy;
    logic [RADIUS_IN_W-1:0]     rad;
    logic                       fill;
    logic                       idle_exp;  // expected reply is the idle word
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic                       in_op = OP_START;
  logic signed [CENTRE_W-1:0] in_center_x = '0;
  logic signed [CENTRE_W-1:0] in_center_y = '0;
  logic [RADIUS_IN_W-1:0]     in_radius_in = '0;
  logic                       in_fill_req = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [COORD_W-1:0]  out_row_y;
  logic signed [COORD_W-1:0]  out_left_x;
  logic signed [COORD_W-1:0]  out_right_x;
  logic                       out_span_mode;
  logic                       out_status;
  logic                       out_last_row;
  logic                       out_circle_done;

  midpoint_circle_row_generator_top #(.RADIUS_WIDTH(RADIUS_WIDTH)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_op          (in_op),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius_in   (in_radius_in),
    .in_fill_req    (in_fill_req),
    .empty          (empty),
    .pop            (pop),
    .out_row_y      (out_row_y),
    .out_left_x     (out_left_x),
    .out_right_x    (out_right_x),
    .out_span_mode  (out_span_mode),
    .out_status     (out_status),
    .out_last_row   (out_last_row),
    .out_circle_done(out_circle_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Rasteriser state as seen by the checker.
  int   c_col, c_row, x_off, y_off, x_odd, y_odd, err_acc, two_r;
  logic fill_on, drawing;

  row_word_t pending_rows[$];
  dir_row_t  dir_tab[$];

  int  errors = 0;
  int  n_words = 0, n_starts = 0, n_rows = 0, n_done = 0, n_idle = 0;
  int  n_rand = 0;
  int  send_idle_pct = 7, recv_idle_pct = 83;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;

  function automatic row_word_t make_row(input int row, input int lx, input int rx,
                                         input logic last, input logic fin);
    row_word_t w;
    w.row_y       = row[COORD_W-1:0];
    w.left_x      = lx[COORD_W-1:0];
    w.right_x     = rx[COORD_W-1:0];
    w.span_mode   = fill_on;
    w.status      = 1'b0;
    w.last_row    = last;
    w.circle_done = fin;
    return w;
  endfunction

  // Applies one accepted word to the local state and queues the rows it yields.
  function automatic void trace_circle(input dir_row_t wd);
    int        r, x, y;
    logic      fin;
    row_word_t w;
    if (wd.op == OP_START) begin
      r       = int'(wd.rad) & ((1 << RADIUS_WIDTH) - 1);
      c_col   = int'(wd.cx);
      c_row   = int'(wd.cy);
      fill_on = wd.fill;
      two_r   = 2 * r;
      x_off   = r - 1;
      y_off   = 0;
      x_odd   = 1;
      y_odd   = 1;
      err_acc = 1 - two_r;
      drawing = (x_off >= y_off);
      return;
    end
    if (!drawing) begin
      w          = '0;
      w.status   = 1'b1;
      w.last_row = 1'b1;
      pending_rows.push_back(w);
      return;
    end
    x = x_off;
    y = y_off;
    if (err_acc <= 0) begin
      y_off   = y_off + 1;
      err_acc = err_acc + y_odd;
      y_odd   = y_odd + 2;
    end
    if (err_acc > 0) begin
      x_off   = x_off - 1;
      x_odd   = x_odd + 2;
      err_acc = err_acc + x_odd - two_r;
    end
    fin = (x_off < y_off);
    if (fin) drawing = 1'b0;
    pending_rows.push_back(make_row(c_row - y, c_col - x, c_col + x, 1'b0, 1'b0));
    pending_rows.push_back(make_row(c_row + y, c_col - x, c_col + x, 1'b0, 1'b0));
    pending_rows.push_back(make_row(c_row - x, c_col - y, c_col + y, 1'b0, 1'b0));
    pending_rows.push_back(make_row(c_row + x, c_col - y, c_col + y, 1'b1, fin));
  endfunction

  task automatic send_word(input dir_row_t wd);
    row_word_t w;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_op        <= wd.op;
    in_center_x  <= wd.cx;
    in_center_y  <= wd.cy;
    in_radius_in <= wd.rad;
    in_fill_req  <= wd.fill;
    @(posedge clk);
    while (full) @(posedge clk);
    if (wd.idle_exp) begin
      w          = '0;
      w.status   = 1'b1;
      w.last_row = 1'b1;
      pending_rows.push_back(w);
    end else begin
      trace_circle(wd);
    end
    n_words++;
    if (wd.op == OP_START) n_starts++;
  endtask

  // The sender stops offering words until every predicted row has been popped.
  task automatic drain_wait();
    push <= 1'b0;
    do @(posedge clk); while (pending_rows.size() != 0);
  endtask

  task automatic send_random(input dir_row_t wd);
    if (n_rand == RANDOM_WORDS / 3) begin
      drain_wait();
      send_idle_pct = 83;
      recv_idle_pct = 7;
    end
    if (n_rand == 2 * RANDOM_WORDS / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req      = 1'b1;
    end
    send_word(wd);
    n_rand++;
  endtask

  // Result side: check each popped word, then choose pop for the next cycle.
  initial begin
    row_word_t got, exp_w;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (pop && !empty) begin
          got = '{out_row_y, out_left_x, out_right_x, out_span_mode,
                  out_status, out_last_row, out_circle_done};
          n_rows++;
          if (out_circle_done) n_done++;
          if (out_status) n_idle++;
          if (pending_rows.size() == 0) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: unexpected word row=%0d l=%0d r=%0d st=%0b",
                       got.row_y, got.left_x, got.right_x, got.status);
          end else begin
            exp_w = pending_rows.pop_front();
            if (got !== exp_w) begin
              errors++;
              if (errors <= 10) begin
                $display("ERROR: row word mismatch exp row=%0d l=%0d r=%0d span=%0b st=%0b last=%0b done=%0b",
                         exp_w.row_y, exp_w.left_x, exp_w.right_x, exp_w.span_mode,
                         exp_w.status, exp_w.last_row, exp_w.circle_done);
                $display("       got row=%0d l=%0d r=%0d span=%0b st=%0b last=%0b done=%0b",
                         got.row_y, got.left_x, got.right_x, got.span_mode,
                         got.status, got.last_row, got.circle_done);
              end
            end
          end
        end
        if (hold_req) begin
          hold_req = 1'b0;
          hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
          hold_cnt--;
          pop <= 1'b0;
        end else begin
          pop <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
        end
      end
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    dir_row_t wd;
    int       r, n, sel;
    c_col   = 0;
    c_row   = 0;
    x_off   = 0;
    y_off   = 0;
    x_odd   = 1;
    y_odd   = 1;
    err_acc = 0;
    two_r   = 0;
    fill_on = 1'b0;
    drawing = 1'b0;

    // Idle step after reset, zero radius, smallest and largest circles at the
    // corners of the centre range, a restart mid-circle and a run to the end.
    dir_tab.push_back(dir_row_t'{OP_STEP,  16'sh0000, 16'sh0000, 10'd0,    1'b0, 1'b1});
    dir_tab.push_back(dir_row_t'{OP_START, 16'sh0000, 16'sh0000, 10'd0,    1'b0, 1'b0});
    dir_tab.push_back(dir_row_t'{OP_STEP,  16'sh0000, 16'sh0000, 10'd0,    1'b0, 1'b1});
    dir_tab.push_back(dir_row_t'{OP_START, 16'sh7FFF, 16'sh8000, 10'd1,    1'b1, 1'b0});
    dir_tab.push_back(dir_row_t'{OP_STEP,  16'sh0000, 16'sh0000, 10'd0,    1'b0, 1'b0});
    dir_tab.push_back(dir_row_t'{OP_STEP,  16'sh0000, 16'sh0000, 10'd0,    1'b0, 1'b1});
    dir_tab.push_back(dir_row_t'{OP_START, 16'sh8000, 16'sh7FFF, 10'd1023, 1'b0, 1'b0});
    for (int i = 0; i < 3; i++)
      dir_tab.push_back(dir_row_t'{OP_STEP, 16'shFFFF, 16'shFFFF, 10'd1023, 1'b1, 1'b0});
    dir_tab.push_back(dir_row_t'{OP_START, 16'sh0064, 16'shFF9C, 10'd5,    1'b1, 1'b0});
    for (int i = 0; i < 6; i++)
      dir_tab.push_back(dir_row_t'{OP_STEP, 16'sh0000, 16'sh0000, 10'd0, 1'b0, 1'b0});
    dir_tab.push_back(dir_row_t'{OP_START, 16'shFFFF, 16'shFFFF, 10'd2,    1'b0, 1'b0});
    for (int i = 0; i < 3; i++)
      dir_tab.push_back(dir_row_t'{OP_STEP, 16'sh0000, 16'sh0000, 10'd0, 1'b0, 1'b0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i]);

    while (n_rand < RANDOM_WORDS) begin
      wd = '0;
      if ($urandom_range(9) == 0) begin
        // Stray word with every field random.
        wd.op   = 1'($urandom_range(1));
        wd.cx   = CENTRE_W'($urandom);
        wd.cy   = CENTRE_W'($urandom);
        wd.rad  = RADIUS_IN_W'($urandom);
        wd.fill = 1'($urandom_range(1));
        send_random(wd);
      end else begin
        sel = $urandom_range(99);
        if (sel < 70)      r = $urandom_range(12, 1);
        else if (sel < 92) r = $urandom_range(60, 13);
        else               r = $urandom_range(1023, 0);
        wd.op   = OP_START;
        wd.cx   = CENTRE_W'($urandom);
        wd.cy   = CENTRE_W'($urandom);
        wd.rad  = RADIUS_IN_W'(r);
        wd.fill = 1'($urandom_range(1));
        send_random(wd);
        // Enough steps to finish a small circle, sometimes one spare for the
        // idle reply, sometimes cut short by the next start.
        if (r <= 60) n = r * 3 / 4 + 2 + $urandom_range(1);
        else         n = $urandom_range(6, 1);
        if ($urandom_range(3) == 0) n = $urandom_range(n, 0);
        for (int k = 0; k < n && n_rand < RANDOM_WORDS; k++) begin
          wd.op  = OP_STEP;
          wd.cx  = CENTRE_W'($urandom);
          wd.cy  = CENTRE_W'($urandom);
          wd.rad = RADIUS_IN_W'($urandom);
          send_random(wd);
        end
      end
    end

    push <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += pending_rows.size();

    $display("Sent %0d words (%0d starts), checked %0d row words.",
             n_words, n_starts, n_rows);
    $display("Circles completed: %0d, idle replies: %0d.", n_done, n_idle);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatch count: %0d", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mcrg_pkg.sv
rtl/mcrg_front.sv
rtl/mcrg_queue.sv
rtl/mcrg_back.sv
rtl/midpoint_circle_row_generator_top.sv
dv/tb_top.sv
